### rtl/i2c_eeprom_byte_master_defines.svh
// assertion macros for the serial eeprom master
`ifndef I2C_EEPROM_BYTE_MASTER_DEFINES_SVH
`define I2C_EEPROM_BYTE_MASTER_DEFINES_SVH
`ifndef SYNTH
`define IEBM_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("iebm: same-cycle check failed");
`define IEBM_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("iebm: next-cycle check failed");
`else
`define IEBM_ASSERT_IMP(label, clk, rst, ante, cons)
`define IEBM_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/iebm_pkg.sv
`timescale 1ns / 1ps
package iebm_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_TICKS    = 1'b1;

  localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'd80;
  localparam logic [7:0] PHASE_TICKS_RESET    = 8'd2;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // sequencer step codes
  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_START   = 5'd1;
  localparam logic [4:0] ST_DEVW_H  = 5'd5;
  localparam logic [4:0] ST_ACK0_H  = 5'd7;
  localparam logic [4:0] ST_ADDR_L  = 5'd8;
  localparam logic [4:0] ST_ADDR_H  = 5'd9;
  localparam logic [4:0] ST_ACK1_H  = 5'd11;
  localparam logic [4:0] ST_WDATA_L = 5'd12;
  localparam logic [4:0] ST_WDATA_H = 5'd13;
  localparam logic [4:0] ST_ACK2_H  = 5'd15;
  localparam logic [4:0] ST_RSTART  = 5'd16;
  localparam logic [4:0] ST_RS_LAST = 5'd19;
  localparam logic [4:0] ST_DEVR_L  = 5'd20;
  localparam logic [4:0] ST_DEVR_H  = 5'd21;
  localparam logic [4:0] ST_ACK3_H  = 5'd23;
  localparam logic [4:0] ST_RDATA_L = 5'd24;
  localparam logic [4:0] ST_RDATA_H = 5'd25;
  localparam logic [4:0] ST_MNAK_L  = 5'd26;
  localparam logic [4:0] ST_STOP_A  = 5'd28;
  localparam logic [4:0] ST_STOP_C  = 5'd30;
  localparam logic [4:0] ST_UNUSED  = 5'd31;

  // sda modes
  localparam logic [1:0] LV_LOW  = 2'd0;
  localparam logic [1:0] LV_HIGH = 2'd1;
  localparam logic [1:0] LV_BIT  = 2'd2;
  localparam logic [1:0] LV_REL  = 2'd3;

  localparam logic SCL_TAB [32] = '{
    1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1,
    1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1,
    1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1,
    1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};

  localparam logic [1:0] SDA_TAB [32] = '{
    LV_HIGH, LV_HIGH, LV_LOW,  LV_LOW,  LV_BIT,  LV_BIT,  LV_REL,  LV_REL,
    LV_BIT,  LV_BIT,  LV_REL,  LV_REL,  LV_BIT,  LV_BIT,  LV_REL,  LV_REL,
    LV_HIGH, LV_HIGH, LV_LOW,  LV_LOW,  LV_BIT,  LV_BIT,  LV_REL,  LV_REL,
    LV_REL,  LV_REL,  LV_HIGH, LV_HIGH, LV_LOW,  LV_LOW,  LV_HIGH, LV_HIGH};

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] mem_addr;
    logic [7:0] write_data;
    logic       sda_in;
  } cmd_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic       nak_error;
    logic [7:0] rx_data;
  } result_t;

endpackage

### rtl/iebm_ifs.sv
`timescale 1ns / 1ps
interface iebm_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] mem_addr;
  logic [7:0] write_data;
  logic       sda_in;

  modport source (output valid, action, mem_addr, write_data, sda_in, input ready);
  modport sink (input valid, action, mem_addr, write_data, sda_in, output ready);
endinterface

interface iebm_res_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_drive;
  logic       busy_res;
  logic       done_res;
  logic       nak_error;
  logic [7:0] rx_data;

  modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                  nak_error, rx_data, input ready);
  modport sink (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                nak_error, rx_data, output ready);
endinterface

### rtl/iebm_seq.sv
`timescale 1ns / 1ps
module iebm_seq
  import iebm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  input  logic                  step_en,
  input  cmd_t                  cmd,
  output result_t               result,
  output logic                  seq_idle
);

  logic [6:0] device_address;
  logic [7:0] phase_ticks;

  logic [4:0] seq_step, seq_step_next;
  logic [3:0] bit_count, bit_count_next;
  logic [7:0] shift_reg, shift_reg_next;
  logic [7:0] tick_count, tick_count_next;
  logic       op_is_read, op_is_read_next;
  logic [7:0] latched_addr, latched_addr_next;
  logic [7:0] latched_data, latched_data_next;
  logic       nak_flag, nak_flag_next;

  logic       start;
  logic [4:0] st;
  logic [1:0] mode;
  logic [3:0] bc_inc;
  logic [7:0] tick_inc;
  logic [7:0] limit;

  assign seq_idle = (seq_step == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= DEVICE_ADDRESS_RESET;
      phase_ticks    <= PHASE_TICKS_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_DEVICE_ADDRESS: device_address <= wr_data[6:0];
        REG_PHASE_TICKS:    phase_ticks    <= wr_data;
        default:            ;
      endcase
    end
  end

  always_comb begin
    seq_step_next     = seq_step;
    bit_count_next    = bit_count;
    shift_reg_next    = shift_reg;
    tick_count_next   = tick_count;
    op_is_read_next   = op_is_read;
    latched_addr_next = latched_addr;
    latched_data_next = latched_data;
    nak_flag_next     = nak_flag;
    limit             = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
    result            = '0;

    start = seq_idle && (cmd.action == ACT_WRITE || cmd.action == ACT_READ);
    if (start) begin
      op_is_read_next   = (cmd.action == ACT_READ);
      latched_addr_next = cmd.mem_addr;
      latched_data_next = cmd.write_data;
      shift_reg_next    = {device_address, 1'b0};
      bit_count_next    = 4'd0;
      tick_count_next   = 8'd0;
      nak_flag_next     = 1'b0;
      seq_step_next     = ST_START;
    end

    st   = seq_step_next;
    mode = SDA_TAB[st];
    result.scl_level = SCL_TAB[st];
    result.sda_drive = (mode != LV_REL);
    unique case (mode)
      LV_LOW:  result.sda_level = 1'b0;
      LV_BIT:  result.sda_level = shift_reg_next[7];
      default: result.sda_level = 1'b1;
    endcase

    bc_inc   = bit_count_next + 4'd1;
    tick_inc = tick_count_next + 8'd1;

    if (st != ST_IDLE) begin
      result.busy_res = 1'b1;
      tick_count_next = tick_inc;
      if (tick_inc >= limit) begin
        tick_count_next = 8'd0;
        unique case (st)
          ST_IDLE: ;
          ST_DEVW_H, ST_ADDR_H, ST_WDATA_H, ST_DEVR_H: begin
            shift_reg_next = {shift_reg_next[6:0], 1'b0};
            if (bc_inc >= 4'd8) begin
              bit_count_next = 4'd0;
              seq_step_next  = st + 5'd1;
            end else begin
              bit_count_next = bc_inc;
              seq_step_next  = st - 5'd1;
            end
          end
          ST_ACK0_H, ST_ACK1_H, ST_ACK2_H, ST_ACK3_H: begin
            if (cmd.sda_in) begin
              nak_flag_next = 1'b1;
              seq_step_next = ST_STOP_A;
            end else begin
              unique case (st)
                ST_ACK0_H: begin
                  shift_reg_next = latched_addr_next;
                  seq_step_next  = ST_ADDR_L;
                end
                ST_ACK1_H: begin
                  if (op_is_read_next) begin
                    seq_step_next = ST_RSTART;
                  end else begin
                    shift_reg_next = latched_data_next;
                    seq_step_next  = ST_WDATA_L;
                  end
                end
                ST_ACK2_H: seq_step_next = ST_STOP_A;
                default: begin
                  shift_reg_next = 8'd0;
                  bit_count_next = 4'd0;
                  seq_step_next  = ST_RDATA_L;
                end
              endcase
            end
          end
          ST_RS_LAST: begin
            shift_reg_next = {device_address, 1'b1};
            bit_count_next = 4'd0;
            seq_step_next  = ST_DEVR_L;
          end
          ST_RDATA_H: begin
            shift_reg_next = {shift_reg_next[6:0], cmd.sda_in};
            if (bc_inc >= 4'd8) begin
              bit_count_next = 4'd0;
              seq_step_next  = ST_MNAK_L;
            end else begin
              bit_count_next = bc_inc;
              seq_step_next  = ST_RDATA_L;
            end
          end
          ST_STOP_C: begin
            seq_step_next    = ST_IDLE;
            result.busy_res  = 1'b0;
            result.done_res  = 1'b1;
            result.nak_error = nak_flag_next;
            result.rx_data   = (op_is_read_next && !nak_flag_next) ? shift_reg_next : 8'd0;
          end
          ST_UNUSED: seq_step_next = ST_IDLE;
          default:   seq_step_next = st + 5'd1;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_step     <= ST_IDLE;
      bit_count    <= 4'd0;
      shift_reg    <= 8'd0;
      tick_count   <= 8'd0;
      op_is_read   <= 1'b0;
      latched_addr <= 8'd0;
      latched_data <= 8'd0;
      nak_flag     <= 1'b0;
    end else if (step_en) begin
      seq_step     <= seq_step_next;
      bit_count    <= bit_count_next;
      shift_reg    <= shift_reg_next;
      tick_count   <= tick_count_next;
      op_is_read   <= op_is_read_next;
      latched_addr <= latched_addr_next;
      latched_data <= latched_data_next;
      nak_flag     <= nak_flag_next;
    end
  end

endmodule

### rtl/iebm_out_reg.sv
`timescale 1ns / 1ps
module iebm_out_reg
  import iebm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load_req,
  input  result_t    data,
  output logic       space,
  iebm_res_if.source res
);

  logic    valid;
  result_t payload;

  assign space = !valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (space) begin
      valid <= load_req;
    end
  end

  always_ff @(posedge clk) begin
    if (space && load_req) begin
      payload <= data;
    end
  end

  assign res.valid     = valid;
  assign res.scl_level = payload.scl_level;
  assign res.sda_level = payload.sda_level;
  assign res.sda_drive = payload.sda_drive;
  assign res.busy_res  = payload.busy_res;
  assign res.done_res  = payload.done_res;
  assign res.nak_error = payload.nak_error;
  assign res.rx_data   = payload.rx_data;

endmodule

### rtl/i2c_eeprom_byte_master.sv
`timescale 1ns / 1ps
`include "i2c_eeprom_byte_master_defines.svh"
// Tick-driven I2C master for a serial EEPROM doing a byte write or a random read.
// Each transfer on cmd is one bus tick and yields exactly one transfer on res with
// the SCL/SDA levels, busy, done, nak and read data for that tick. A new tick is
// taken every clock cycle: the sequencer state updates in the cycle of the tick and
// the result sits in a one-entry output register, so cmd is ready whenever that
// register is empty or being drained. Every bus phase lasts phase_ticks ticks
// (0 acts as 1). A missing acknowledge issues a stop and ends with nak_error set and
// rx_data zero. Commands arriving while busy are ignored. Registers are written
// through wr_en/wr_index/wr_data: index 0 device_address, index 1 phase_ticks.
module i2c_eeprom_byte_master
  import iebm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  iebm_cmd_if.sink              cmd,
  iebm_res_if.source            res
);

  cmd_t    cmd_item;
  result_t step_result;
  logic    space;
  logic    step_en;
  logic    seq_idle;
  logic    cmd_start;
  logic    bus_released;

  assign cmd_item.action     = cmd.action;
  assign cmd_item.mem_addr   = cmd.mem_addr;
  assign cmd_item.write_data = cmd.write_data;
  assign cmd_item.sda_in     = cmd.sda_in;

  assign cmd.ready = space;
  assign step_en   = cmd.valid && space;

  assign cmd_start    = step_en && seq_idle && (cmd.action == ACT_WRITE || cmd.action == ACT_READ);
  assign bus_released = res.scl_level && res.sda_level && res.sda_drive;

  iebm_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .step_en  (step_en),
    .cmd      (cmd_item),
    .result   (step_result),
    .seq_idle (seq_idle)
  );

  iebm_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load_req (cmd.valid),
    .data     (step_result),
    .space    (space),
    .res      (res)
  );

  `IEBM_ASSERT_IMP(a_idle_bus, clk, rst, res.valid && !res.busy_res, bus_released)
  `IEBM_ASSERT_IMP(a_done_not_busy, clk, rst, res.valid && res.done_res, !res.busy_res)
  `IEBM_ASSERT_IMP(a_nak_clears_data, clk, rst, res.valid && res.nak_error, res.done_res && (res.rx_data == '0))
  `IEBM_ASSERT_NXT(a_cmd_starts, clk, rst, cmd_start, res.valid && res.busy_res)

endmodule
